// File: sv/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and constants for the TLV frame deframer with resync.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvd_pkg;

    // Tag byte plus length byte in front of every value.
    localparam int HDR_LEN   = 2;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAG_KEEPALIVE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_EVENT         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_DATA          = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_TIME_RESPONSE = 8'd3;

    // Tag register values after reset.
    localparam logic [7:0] RST_TAG_KEEPALIVE     = 8'd0;
    localparam logic [7:0] RST_TAG_EVENT         = 8'd1;
    localparam logic [7:0] RST_TAG_DATA          = 8'd2;
    localparam logic [7:0] RST_TAG_TIME_RESPONSE = 8'd3;

    typedef struct packed {
        logic [7:0] tag_keepalive;
        logic [7:0] tag_event;
        logic [7:0] tag_data;
        logic [7:0] tag_time_response;
    } t_tags;

    // Sequencer to output stage: one frame byte, or end of the item's run.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       frame_end;
        logic       flush;
    } t_emit;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAG,
        ST_LEN,
        ST_CHILD,
        ST_CHILD_LEN,
        ST_EMIT_RD,
        ST_EMIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: sv/tlvd_ram.sv
// ----------------------------------------------------------------------------
// tlvd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/tlvd_ostage.sv
// ----------------------------------------------------------------------------
// tlvd_ostage
// Output stage: a hold register for the newest frame byte and the output
// register. The hold lets the last byte of an item be marked once the
// sequencer knows that no further frame follows.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_ostage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlvd_pkg::t_emit i_emit,
    output logic                 o_room,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] frame_byte
    output logic                 m_axis_tlast,   // frame_end
    output logic                 m_axis_tuser    // [0] last result of the item
);

    import tlvd_pkg::*;

    logic       r_hv;
    logic [7:0] r_hdata;
    logic       r_hend;
    logic       r_ov;
    logic [7:0] r_odata;
    logic       r_oend;
    logic       r_olast;

    logic w_slot_free;
    logic w_push;
    logic w_flush;
    logic w_move;

    // The output register can take the held item when empty or draining.
    assign w_slot_free = !r_ov || m_axis_tready;
    assign o_room      = !r_hv || w_slot_free;
    assign w_push      = i_emit.valid && o_room;
    assign w_flush     = i_emit.flush && o_room;
    assign w_move      = r_hv && (w_push || w_flush);

    // Hold register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (w_push) begin
            r_hv <= 1'b1;
        end else if (w_flush) begin
            r_hv <= 1'b0;
        end
    end

    // Hold register payload.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hdata <= i_emit.data;
            r_hend  <= i_emit.frame_end;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_move) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    // Output register payload; a flush marks the held byte as the last one.
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_odata <= r_hdata;
            r_oend  <= r_hend;
            r_olast <= w_flush;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_oend;
    assign m_axis_tuser  = r_olast;

    // A completed flush leaves nothing held back.
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_flush && !w_push) |=> !r_hv)
        else $error("hold register still full after flush");

    // A taken byte is always kept in the hold register.
    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_hv)
        else $error("pushed byte lost");

endmodule

`default_nettype wire

// File: sv/tlvd_seq.sv
// ----------------------------------------------------------------------------
// tlvd_seq
// Sequencer of the deframer: keeps the circular window, rescans it for a
// tag, checks the length, walks the child TLVs and sends frames out, all
// through one read port and one shared address adder.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_seq #(
    parameter int MAX_VALUE_LEN = 48
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlvd_pkg::t_tags i_tags,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,   // [7:0] rx_byte
    output tlvd_pkg::t_emit      o_emit,
    input  wire logic            i_room
);

    import tlvd_pkg::*;

    localparam int DEPTH  = MAX_VALUE_LEN + HDR_LEN;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_VALUE_LEN);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head,  n_head;
    logic [FILL_W-1:0]  r_fill,  n_fill;
    logic [7:0]         r_tag,   n_tag;
    logic [7:0]         r_len,   n_len;
    logic [7:0]         r_i,     n_i;
    logic [FILL_W-1:0]  r_k,     n_k;

    logic               w_we;
    logic               w_re;
    logic [PTR_W-1:0]   w_addr;
    logic [7:0]         w_rdata;
    logic [PTR_W:0]     w_off;
    logic [FILL_W-1:0]  w_drop_n;
    logic [PTR_W-1:0]   w_head_adv;
    logic               w_full;
    logic               w_rd_any;
    logic               w_tag_nested;
    logic               w_len_bad;
    logic               w_short_hdr;
    logic               w_short_frame;
    logic               w_child_done;
    logic               w_child_hdr_bad;
    logic [9:0]         w_child_next;
    logic               w_child_bad;
    logic [FILL_W-1:0]  w_total;
    logic               w_emit_end;

    // Modulo-DEPTH add of a pointer and an offset below DEPTH+1.
    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W:0] sum);
        logic [PTR_W:0] red;
        red = sum;
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            red = sum - (PTR_W+1)'(DEPTH);
        end
        return red[PTR_W-1:0];
    endfunction

    // Window storage.
    tlvd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (s_axis_tdata),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Tag and length checks on the byte just read.
    assign w_full        = r_fill == FILL_W'(DEPTH);
    assign w_rd_any      = w_rdata == i_tags.tag_keepalive || w_rdata == i_tags.tag_event ||
                           w_rdata == i_tags.tag_data || w_rdata == i_tags.tag_time_response;
    assign w_tag_nested  = r_tag == i_tags.tag_keepalive || r_tag == i_tags.tag_event ||
                           r_tag == i_tags.tag_data;
    assign w_len_bad     = w_rdata > MAX_LEN;
    assign w_short_hdr   = r_fill < FILL_W'(HDR_LEN);
    assign w_short_frame = 9'(r_fill) < (9'(HDR_LEN) + 9'(w_rdata));

    // Child walk: r_i is the offset of the next child inside the value.
    assign w_child_done    = r_i == r_len;
    assign w_child_hdr_bad = (9'(r_i) + 9'(HDR_LEN)) > 9'(r_len);
    assign w_child_next    = 10'(r_i) + 10'(HDR_LEN) + 10'(w_rdata);
    assign w_child_bad     = w_child_next > 10'(r_len);

    // Frame emission bookkeeping.
    assign w_total    = FILL_W'(HDR_LEN) + FILL_W'(r_len);
    assign w_emit_end = r_k == (w_total - FILL_W'(1));

    // Offset from the window head for the shared address adder.
    always_comb begin
        case (r_state)
            ST_IDLE:    w_off = w_full ? '0 : (PTR_W+1)'(r_fill);
            ST_TAG:     w_off = (PTR_W+1)'(1);
            ST_CHILD:   w_off = (PTR_W+1)'(10'(r_i) + 10'(HDR_LEN) + 10'd1);
            ST_EMIT_RD: w_off = (PTR_W+1)'(r_k);
            default:    w_off = '0;
        endcase
    end

    assign w_addr     = f_wrap((PTR_W+1)'(r_head) + w_off);
    assign w_drop_n   = (r_state == ST_EMIT) ? w_total : FILL_W'(1);
    assign w_head_adv = f_wrap((PTR_W+1)'(r_head) + (PTR_W+1)'(w_drop_n));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_state = (r_fill == '0) ? ST_DONE : ST_TAG;
            end
            ST_TAG: begin
                if (!w_rd_any)        n_state = ST_SCAN;
                else if (w_short_hdr) n_state = ST_DONE;
                else                  n_state = ST_LEN;
            end
            ST_LEN: begin
                if (w_len_bad)          n_state = ST_SCAN;
                else if (w_short_frame) n_state = ST_DONE;
                else if (w_tag_nested)  n_state = ST_CHILD;
                else                    n_state = ST_EMIT_RD;
            end
            ST_CHILD: begin
                if (w_child_done)         n_state = ST_EMIT_RD;
                else if (w_child_hdr_bad) n_state = ST_SCAN;
                else                      n_state = ST_CHILD_LEN;
            end
            ST_CHILD_LEN: begin
                n_state = w_child_bad ? ST_SCAN : ST_CHILD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_room) n_state = w_emit_end ? ST_SCAN : ST_EMIT_RD;
            end
            ST_DONE: begin
                if (i_room) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_head          = r_head;
        n_fill          = r_fill;
        n_tag           = r_tag;
        n_len           = r_len;
        n_i             = r_i;
        n_k             = r_k;
        w_we            = 1'b0;
        w_re            = 1'b0;
        o_emit.valid    = 1'b0;
        o_emit.data     = w_rdata;
        o_emit.frame_end = w_emit_end;
        o_emit.flush    = 1'b0;
        s_axis_tready   = r_state == ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_we = 1'b1;
                    // A full window loses its oldest byte to the new one.
                    if (w_full) n_head = w_head_adv;
                    else        n_fill = r_fill + FILL_W'(1);
                end
            end
            ST_SCAN: begin
                w_re = r_fill != '0;
            end
            ST_TAG: begin
                if (!w_rd_any) begin
                    n_head = w_head_adv;
                    n_fill = r_fill - FILL_W'(1);
                end else if (!w_short_hdr) begin
                    n_tag = w_rdata;
                    w_re  = 1'b1;
                end
            end
            ST_LEN: begin
                if (w_len_bad) begin
                    n_head = w_head_adv;
                    n_fill = r_fill - FILL_W'(1);
                end else if (!w_short_frame) begin
                    n_len = w_rdata;
                    n_i   = '0;
                    n_k   = '0;
                end
            end
            ST_CHILD: begin
                if (!w_child_done) begin
                    if (w_child_hdr_bad) begin
                        n_head = w_head_adv;
                        n_fill = r_fill - FILL_W'(1);
                    end else begin
                        w_re = 1'b1;
                    end
                end
            end
            ST_CHILD_LEN: begin
                if (w_child_bad) begin
                    n_head = w_head_adv;
                    n_fill = r_fill - FILL_W'(1);
                end else begin
                    n_i = w_child_next[7:0];
                end
            end
            ST_EMIT_RD: begin
                w_re = 1'b1;
            end
            ST_EMIT: begin
                o_emit.valid = 1'b1;
                if (i_room) begin
                    if (w_emit_end) begin
                        n_head = w_head_adv;
                        n_fill = r_fill - w_total;
                    end else begin
                        n_k = r_k + FILL_W'(1);
                    end
                end
            end
            ST_DONE: begin
                o_emit.flush = 1'b1;
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
        end
    end

    // Working registers of the current scan.
    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_len <= n_len;
        r_i   <= n_i;
        r_k   <= n_k;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("window fill above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < PTR_W'(DEPTH))
        else $error("window head out of range");

    a_child_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHILD) |-> (r_i <= r_len))
        else $error("child walk passed the value length");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_fill != '0))
        else $error("accepted item left the window empty");

endmodule

`default_nettype wire

// File: sv/tlv_frame_resync_deframer.sv
// ----------------------------------------------------------------------------
// tlv_frame_resync_deframer
// TLV deframer with resynchronization on received link bytes.
// ----------------------------------------------------------------------------
// Each accepted byte is appended to a window of MAX_VALUE_LEN+2 bytes held in
// a RAM with one registered read port. The block then rescans the window one
// read at a time: leading non-tag bytes are dropped, an oversize length drops
// the tag, and a report frame's children are walked one header per read. A
// valid frame leaves on the master side byte by byte, tlast on its final
// byte and tuser on the final byte released by the input byte. The slave side
// is ready only between items, and register writes are taken only then. The
// single RAM read port and its read latency set the cost of an item, which
// holds the slave side through the accept, the head read and a closing step.
// Each byte dropped from the head adds a read and a tag check, a length check
// adds a step, each child header a read and a check, and each emitted byte a
// read plus any output stall. The worst case is a resync in which every
// position of a full window starts a report frame whose child walk fails at
// its end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_frame_resync_deframer #(
    parameter int MAX_VALUE_LEN = 48
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tlvd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] frame_byte
    output logic                                m_axis_tlast,   // frame_end
    output logic                                m_axis_tuser    // [0] last
);

    import tlvd_pkg::*;

    t_tags r_tags;
    t_emit w_emit;
    logic  w_room;

    // Tags may only change while no item is being scanned.
    assign o_cfg_ready = s_axis_tready;

    // Tag registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags.tag_keepalive     <= RST_TAG_KEEPALIVE;
            r_tags.tag_event         <= RST_TAG_EVENT;
            r_tags.tag_data          <= RST_TAG_DATA;
            r_tags.tag_time_response <= RST_TAG_TIME_RESPONSE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TAG_KEEPALIVE:     r_tags.tag_keepalive     <= i_cfg_data;
                REG_TAG_EVENT:         r_tags.tag_event         <= i_cfg_data;
                REG_TAG_DATA:          r_tags.tag_data          <= i_cfg_data;
                REG_TAG_TIME_RESPONSE: r_tags.tag_time_response <= i_cfg_data;
                default:               r_tags <= r_tags;
            endcase
        end
    end

    // Window sequencer.
    tlvd_seq #(
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tags        (r_tags),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_emit        (w_emit),
        .i_room        (w_room)
    );

    // Output hold and register stage.
    tlvd_ostage u_ostage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (w_emit),
        .o_room        (w_room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLV deframer with resynchronization.
// ----------------------------------------------------------------------------
// Link bytes go in on the slave stream. A bit-accurate predictor tracks the
// byte window and the tag registers and queues the frame bytes that each
// accepted byte should release. A monitor compares every result on the
// master stream, field by field, against the oldest queued byte. Directed
// cases come first: default tags, retagging with a partial frame held,
// and a tag shared between a report and the time response. Randomized
// phases under several tag settings follow, with a long receiver hold-off among them.
// ----------------------------------------------------------------------------

module tb;
    import tlvd_pkg::*;

    localparam int          MAX_VALUE_LEN = 48;
    localparam int          WIN_DEPTH     = MAX_VALUE_LEN + HDR_LEN;
    localparam int          SETTLE_CYCLES = 3000;
    localparam int          STALL_LIMIT   = 20000;
    localparam int          LONG_HOLD     = 1000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          KIND_TIME     = 3;
    // Indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HIGH = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       item_last;
    } t_frame_byte;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    wire                  o_cfg_ready;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [7:0]           m_axis_tdata;
    wire                  m_axis_tlast;
    wire                  m_axis_tuser;

    // Predictor state and the frame bytes still owed by the block.
    t_tags       model_tags;
    logic [7:0]  rx_window[$];
    t_frame_byte expected_frame_bytes[$];
    t_frame_byte want;

    bit          idling_on     = 1'b1;
    int unsigned sink_hold_req = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned mismatches    = 0;
    int unsigned rx_bytes_taken = 0;
    int unsigned results_checked = 0;
    int unsigned frames_seen   = 0;
    int unsigned cfg_writes    = 0;

    tlv_frame_resync_deframer #(
        .MAX_VALUE_LEN(MAX_VALUE_LEN)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_tdata),        // [7:0] rx_byte
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_axis_tdata),   // [7:0] frame_byte
        .m_axis_tlast (m_axis_tlast),   // frame_end
        .m_axis_tuser (m_axis_tuser)    // [0] last
    );

    always #10 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned draw_idle_cycles();
        int unsigned roll;
        if (!idling_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit is_report_tag(input logic [7:0] t);
        return t == model_tags.tag_keepalive || t == model_tags.tag_event ||
               t == model_tags.tag_data;
    endfunction

    function automatic bit is_known_tag(input logic [7:0] t);
        return is_report_tag(t) || t == model_tags.tag_time_response;
    endfunction

    // True when child TLVs tile the value of the frame at the window head.
    function automatic bit children_tile(input int unsigned vlen);
        int unsigned pos;
        int unsigned clen;
        pos = 0;
        while (pos < vlen) begin
            if (pos + HDR_LEN > vlen) return 1'b0;
            clen = rx_window[HDR_LEN + pos + 1];
            if (pos + HDR_LEN + clen > vlen) return 1'b0;
            pos += HDR_LEN + clen;
        end
        return 1'b1;
    endfunction

    // Appends one link byte and queues every frame byte it releases.
    function automatic void predict_frames(input logic [7:0] rx_byte);
        t_frame_byte released[$];
        t_frame_byte fb;
        int unsigned vlen;
        int unsigned total;
        if (rx_window.size() >= WIN_DEPTH) void'(rx_window.pop_front());
        rx_window.push_back(rx_byte);
        forever begin
            while (rx_window.size() > 0 && !is_known_tag(rx_window[0]))
                void'(rx_window.pop_front());
            if (rx_window.size() < HDR_LEN) break;
            vlen = rx_window[1];
            if (vlen > MAX_VALUE_LEN) begin
                void'(rx_window.pop_front());
                continue;
            end
            total = HDR_LEN + vlen;
            if (rx_window.size() < total) break;
            if (is_report_tag(rx_window[0]) && !children_tile(vlen)) begin
                void'(rx_window.pop_front());
                continue;
            end
            for (int unsigned k = 0; k < total; k++) begin
                fb.data      = rx_window[k];
                fb.frame_end = (k + 1 == total);
                fb.item_last = 1'b0;
                released.push_back(fb);
            end
            repeat (total) void'(rx_window.pop_front());
        end
        if (released.size() > 0) released[released.size() - 1].item_last = 1'b1;
        foreach (released[i]) expected_frame_bytes.push_back(released[i]);
    endfunction

    // Monitor: checks results, feeds the predictor and watches for a hang.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            model_tags = '{RST_TAG_KEEPALIVE, RST_TAG_EVENT, RST_TAG_DATA,
                           RST_TAG_TIME_RESPONSE};
            rx_window.delete();
        end else begin
            if (m_axis_tvalid && m_tready) begin
                moved = 1'b1;
                results_checked++;
                if (m_axis_tlast) frames_seen++;
                if (expected_frame_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: unexpected result byte %02h tlast %0b tuser %0b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = expected_frame_bytes.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.frame_end ||
                        m_axis_tuser !== want.item_last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR: result %0d expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     results_checked, want.data, want.frame_end,
                                     want.item_last, m_axis_tdata, m_axis_tlast,
                                     m_axis_tuser);
                    end
                end
            end
            // A register write in the same cycle applies before the byte is scanned.
            if (cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                cfg_writes++;
                case (cfg_index)
                    REG_TAG_KEEPALIVE:     model_tags.tag_keepalive     = cfg_data;
                    REG_TAG_EVENT:         model_tags.tag_event         = cfg_data;
                    REG_TAG_DATA:          model_tags.tag_data          = cfg_data;
                    REG_TAG_TIME_RESPONSE: model_tags.tag_time_response = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_axis_tready) begin
                moved = 1'b1;
                rx_bytes_taken++;
                predict_frames(s_tdata);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: nothing moved for %0d cycles, %0d results still owed",
                     idle_cycles, expected_frame_bytes.size());
            $display("tlv_frame_resync_deframer test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (sink_hold_req != 0) begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            stall_left = draw_idle_cycles();
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offers one link byte after a random gap; returns at a falling edge.
    task automatic send_rx_byte(input logic [7:0] value);
        repeat (draw_idle_cycles()) @(negedge i_clk);
        s_tdata  = value;
        s_tvalid = 1'b1;
        while (!s_axis_tready) @(negedge i_clk);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_rx_byte(bytes[i]);
    endtask

    // Sender pause until every owed result has come out.
    task automatic wait_results();
        while (expected_frame_bytes.size() != 0) @(negedge i_clk);
    endtask

    // Idle point for register writes: a byte may still be resyncing.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_tags(input t_tags setting);
        write_reg(REG_TAG_KEEPALIVE, setting.tag_keepalive);
        write_reg(REG_TAG_EVENT, setting.tag_event);
        write_reg(REG_TAG_DATA, setting.tag_data);
        write_reg(REG_TAG_TIME_RESPONSE, setting.tag_time_response);
    endtask

    function automatic logic [7:0] tag_of_kind(input int unsigned kind);
        case (kind)
            0:       return model_tags.tag_keepalive;
            1:       return model_tags.tag_event;
            2:       return model_tags.tag_data;
            default: return model_tags.tag_time_response;
        endcase
    endfunction

    // One frame of about target value bytes; nested values are child TLVs.
    function automatic void build_frame(input logic [7:0] tag, input bit nested,
                                        input int unsigned target,
                                        output logic [7:0] frame[$]);
        logic [7:0]  value[$];
        int unsigned room;
        int unsigned clen;
        value = {};
        if (nested) begin
            while (value.size() + HDR_LEN <= target) begin
                room = target - value.size() - HDR_LEN;
                clen = $urandom_range(0, room > 8 ? 8 : room);
                value.push_back(8'($urandom_range(0, 255)));
                value.push_back(8'(clen));
                repeat (clen) value.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            repeat (target) value.push_back(8'($urandom_range(0, 255)));
        end
        frame = {tag, 8'(value.size()), value};
    endfunction

    // Default tags: noise, a time response, a report, oversize length,
    // an empty report, and one byte releasing two frames at once.
    task automatic test_reset_tags();
        t_tags tg;
        tg = model_tags;
        send_bytes('{8'hFF, tg.tag_time_response, 8'h00});
        send_bytes('{tg.tag_keepalive, 8'd2, 8'h07, 8'h00});
        send_bytes('{tg.tag_data, 8'(MAX_VALUE_LEN + 1), tg.tag_data, 8'd0});
        send_bytes('{tg.tag_event, 8'd5, tg.tag_time_response, 8'd0,
                     tg.tag_time_response, 8'd0, 8'h07});
    endtask

    // A partial frame sits in the window while the time-response tag moves.
    task automatic test_retag_midstream();
        send_bytes('{model_tags.tag_time_response, 8'd4, 8'h10});
        wait_idle();
        write_reg(REG_TAG_TIME_RESPONSE, 8'h10);
        send_bytes('{8'h01, 8'hEE});
    endtask

    // Time-response tag equal to the event tag still gets the child check.
    task automatic test_shared_tag();
        wait_idle();
        write_reg(REG_TAG_TIME_RESPONSE, model_tags.tag_event);
        send_bytes('{model_tags.tag_event, 8'd2, 8'h40, 8'h40});
        send_bytes('{model_tags.tag_event, 8'd2, 8'h40, 8'h00});
        wait_idle();
        write_reg(REG_NONE_LOW, 8'h55);
        write_reg(REG_NONE_HIGH, 8'hAA);
        send_bytes('{8'h55, 8'hAA});
    endtask

    // Mostly well-formed frames, some broken ones and some noise.
    task automatic test_random_traffic(input t_tags setting, input int unsigned n_bytes,
                                       input bit with_idling);
        logic [7:0]  frame[$];
        int unsigned sent;
        int unsigned roll;
        int unsigned kind;
        int unsigned target;
        wait_idle();
        write_tags(setting);
        idling_on = with_idling;
        sent = 0;
        while (sent < n_bytes) begin
            roll   = $urandom_range(0, 99);
            kind   = $urandom_range(0, 3);
            target = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MAX_VALUE_LEN)
                                                   : $urandom_range(0, 10);
            build_frame(tag_of_kind(kind), kind != KIND_TIME, target, frame);
            if (roll < 10) begin
                frame[1] = 8'($urandom_range(MAX_VALUE_LEN + 1, 255));
            end else if (roll < 20) begin
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (roll < 26) begin
                frame = frame[0:$urandom_range(0, frame.size() - 1)];
            end else if (roll < 34) begin
                frame = {};
                repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
            end else if (roll < 37) begin
                wait_results();
            end
            send_bytes(frame);
            sent += frame.size();
        end
        idling_on = 1'b1;
    endtask

    // Receiver holds off while valid frames keep coming until input stalls.
    task automatic test_backpressure();
        logic [7:0] frame[$];
        wait_results();
        idling_on = 1'b0;
        @(posedge i_clk);
        sink_hold_req = LONG_HOLD;
        @(negedge i_clk);
        repeat (8) begin
            build_frame(model_tags.tag_keepalive, 1'b1, $urandom_range(2, 10), frame);
            send_bytes(frame);
        end
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_tags();
        test_retag_midstream();
        test_shared_tag();
        test_random_traffic('{8'h7E, 8'h81, 8'hC3, 8'h24}, 70, 1'b0);
        test_random_traffic('{8'hFF, 8'h00, 8'h80, 8'h01}, 70, 1'b1);
        test_backpressure();
        test_random_traffic('{8'h00, 8'h00, 8'h00, 8'hFF}, 70, 1'b1);
        test_random_traffic('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 70, 1'b1);
        wait_idle();

        $display("Covered %0d link bytes, %0d tag writes, %0d frame bytes in %0d frames.",
                 rx_bytes_taken, cfg_writes, results_checked, frames_seen);
        $display("Tag settings included shared and extreme values; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("tlv_frame_resync_deframer test passed");
        end else begin
            $display("tlv_frame_resync_deframer test failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/tlvd_pkg.sv
sv/tlvd_ram.sv
sv/tlvd_ostage.sv
sv/tlvd_seq.sv
sv/tlv_frame_resync_deframer.sv
dv/tb.sv
